### hw/rtl/assert_macros.svh
// Assertion macros used by the merge sorter datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ms_pkg.sv
// Merge sorter shared types and constants
package ms_pkg;

  localparam int VAL_W = 64;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic merge;
    logic emit;
  } ms_cmd_t;

  typedef struct packed {
    logic empty;
    logic small_set;
    logic at_end;
    logic sort_end;
    logic out_free;
  } ms_stat_t;

endpackage

### hw/rtl/ms_if.sv
// Merge sorter input and result stream interfaces
interface ms_in_if;
  logic          valid;
  logic          ready;
  ms_pkg::val_t  value;
  logic          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ms_out_if;
  logic          valid;
  logic          ready;
  ms_pkg::val_t  sorted_value;
  logic          final_res;
  logic          overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

### hw/rtl/ms_ram.sv
// Generic RAM, one write port, two registered read ports
module ms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hw/rtl/ms_datapath.sv
// Merge sorter datapath: ping-pong stores, run pointers, compare, result register
`include "assert_macros.svh"

module ms_datapath #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ms_pkg::ms_cmd_t  cmd,
  output ms_pkg::ms_stat_t st,
  input  ms_pkg::val_t     in_value,
  input  logic             out_ready,
  output logic             out_valid,
  output ms_pkg::val_t     sorted_value,
  output logic             final_res,
  output logic             overflow
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int WW = CW + 1;
  localparam int SW = CW + 2;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic          sel_r, sel_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, mid_r, mid_nxt, hi_r, hi_nxt;
  ms_pkg::val_t  out_val_r, out_val_nxt;
  logic          out_fin_r, out_fin_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic [ms_pkg::VAL_W-1:0] r0a, r0b, r1a, r1b;
  ms_pkg::val_t  rd_a, rd_b, mg_data, wdata;
  logic          we0, we1, ld_we, room, take_j, at_end, sort_end, out_free;
  logic [AW-1:0] waddr;
  logic [CW-1:0] k1, run_mid, run_hi, pass_mid, pass_hi;
  logic [WW-1:0] w2;
  logic [SW-1:0] w4, hw, hw2, n_s;

  assign rd_a    = sel_r ? ms_pkg::val_t'(r1a) : ms_pkg::val_t'(r0a);
  assign rd_b    = sel_r ? ms_pkg::val_t'(r1b) : ms_pkg::val_t'(r0b);
  assign take_j  = (j_r < hi_r) && ((i_r >= mid_r) || (rd_b < rd_a));
  assign mg_data = take_j ? rd_b : rd_a;

  assign room  = cnt_r < CW'(DEPTH);
  assign ld_we = cmd.load && room;
  assign we0   = (ld_we && !sel_r) || (cmd.merge && sel_r);
  assign we1   = (ld_we && sel_r) || (cmd.merge && !sel_r);
  assign waddr = cmd.load ? cnt_r[AW-1:0] : k_r[AW-1:0];
  assign wdata = cmd.load ? in_value : mg_data;

  assign k1       = k_r + CW'(1);
  assign at_end   = (k1 == cnt_r);
  assign n_s      = {2'b00, cnt_r};
  assign w2       = {w_r[WW-2:0], 1'b0};
  assign w4       = {w2, 1'b0};
  assign hw       = {2'b00, hi_r} + {1'b0, w_r};
  assign hw2      = hw + {1'b0, w_r};
  assign run_mid  = (hw >= n_s) ? cnt_r : hw[CW-1:0];
  assign run_hi   = (hw2 >= n_s) ? cnt_r : hw2[CW-1:0];
  assign pass_mid = ({1'b0, w2} >= n_s) ? cnt_r : w2[CW-1:0];
  assign pass_hi  = (w4 >= n_s) ? cnt_r : w4[CW-1:0];
  assign sort_end = ({1'b0, w2} >= n_s);
  assign out_free = !out_valid_r || out_ready;

  assign st.empty     = (cnt_r == '0);
  assign st.small_set = (cnt_r <= CW'(1));
  assign st.at_end    = at_end;
  assign st.sort_end  = sort_end;
  assign st.out_free  = out_free;

  ms_ram #(.WIDTH(ms_pkg::VAL_W), .DEPTH(DEPTH)) u_bank0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata),
    .raddr_a(i_r[AW-1:0]), .raddr_b(j_r[AW-1:0]), .rdata_a(r0a), .rdata_b(r0b)
  );

  ms_ram #(.WIDTH(ms_pkg::VAL_W), .DEPTH(DEPTH)) u_bank1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata),
    .raddr_a(i_r[AW-1:0]), .raddr_b(j_r[AW-1:0]), .rdata_a(r1a), .rdata_b(r1b)
  );

  always_comb begin
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    sel_nxt       = sel_r;
    w_nxt         = w_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    out_val_nxt   = out_val_r;
    out_fin_nxt   = out_fin_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    if (cmd.load) begin
      if (room) begin
        cnt_nxt = cnt_r + CW'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end

    if (cmd.setup) begin
      w_nxt   = WW'(1);
      i_nxt   = '0;
      k_nxt   = '0;
      mid_nxt = (cnt_r >= CW'(1)) ? CW'(1) : cnt_r;
      j_nxt   = (cnt_r >= CW'(1)) ? CW'(1) : cnt_r;
      hi_nxt  = (cnt_r >= CW'(2)) ? CW'(2) : cnt_r;
    end

    if (cmd.merge) begin
      if (at_end) begin
        // pass complete: swap banks, open the first run pair of the next pass
        sel_nxt = !sel_r;
        w_nxt   = w2;
        k_nxt   = '0;
        i_nxt   = '0;
        mid_nxt = pass_mid;
        j_nxt   = pass_mid;
        hi_nxt  = pass_hi;
      end else if (k1 == hi_r) begin
        k_nxt   = k1;
        i_nxt   = hi_r;
        mid_nxt = run_mid;
        j_nxt   = run_mid;
        hi_nxt  = run_hi;
      end else begin
        k_nxt = k1;
        if (take_j) begin
          j_nxt = j_r + CW'(1);
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = rd_a;
      out_fin_nxt   = at_end;
      out_ovf_nxt   = drop_r;
      k_nxt         = k1;
      i_nxt         = i_r + CW'(1);
      if (at_end) begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r       <= w_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    mid_r     <= mid_nxt;
    hi_r      <= hi_nxt;
    out_val_r <= out_val_nxt;
    out_fin_r <= out_fin_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign sorted_value = out_val_r;
  assign final_res    = out_fin_r;
  assign overflow     = out_ovf_r;

  `MS_ASSERT_NOW(a_merge_slot, clk, rst_n, cmd.merge, k_r < cnt_r, "merge past set end")
  `MS_ASSERT_NOW(a_run_bounds, clk, rst_n, cmd.merge, (i_r <= mid_r) && (j_r <= hi_r), "run overrun")
  `MS_ASSERT_NOW(a_emit_free, clk, rst_n, cmd.emit, out_free, "result overwritten")
  `MS_ASSERT_NEXT(a_set_clear, clk, rst_n, cmd.emit && at_end, (cnt_r == '0) && !drop_r, "set not cleared")

endmodule

### hw/rtl/ms_ctrl.sv
// Merge sorter controller: load, merge pass and emit sequencing
module ms_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  ms_pkg::ms_stat_t st,
  output ms_pkg::ms_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_M_RD  = 3'd2;
  localparam logic [2:0] S_M_WR  = 3'd3;
  localparam logic [2:0] S_E_RD  = 3'd4;
  localparam logic [2:0] S_E_WR  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = accept;
        if (accept && in_last) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (st.empty) begin
          state_nxt = S_IDLE;
        end else if (st.small_set) begin
          state_nxt = S_E_RD;
        end else begin
          state_nxt = S_M_RD;
        end
      end
      S_M_RD: begin
        state_nxt = S_M_WR;
      end
      S_M_WR: begin
        cmd.merge = 1'b1;
        state_nxt = (st.at_end && st.sort_end) ? S_E_RD : S_M_RD;
      end
      S_E_RD: begin
        state_nxt = S_E_WR;
      end
      S_E_WR: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = st.at_end ? S_IDLE : S_E_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/merge_sorter.sv
// Loading takes the set beat by beat, then a setup step, then ceil(log2(n)) merge
// passes, each element a registered store read, then compare and write; then each
// result beat is a store read, then an emit that waits until the output is free.
// One set at a time; the next set loads while the final result beat waits.
// Synchronous active-low reset clears the sequencer, element count, drop flag,
// bank select and result valid; the stores are not cleared.
module merge_sorter #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ms_in_if.sink     in_ch,
  ms_out_if.source  out_ch
);

  ms_pkg::ms_cmd_t  cmd;
  ms_pkg::ms_stat_t st;

  ms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  ms_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_value     (in_ch.value),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .sorted_value (out_ch.sorted_value),
    .final_res    (out_ch.final_res),
    .overflow     (out_ch.overflow)
  );

endmodule
